/* rtl/scsp_pkg.sv */
// Shared types, constants and helper functions of the servo pulse sequencer.
`default_nettype none
package scsp_pkg;

  localparam int unsigned NUM_SERVOS       = 6;
  localparam int unsigned MAX_PACKET_CHARS = 9;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PINS_W   = 6;
  localparam int unsigned UPD_CH_W = 3;
  localparam int unsigned SLOT_W   = $clog2(NUM_SERVOS + 1);
  localparam int unsigned CH_W     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int unsigned COUNT_W  = $clog2(MAX_PACKET_CHARS + 1);
  localparam int unsigned USED_W   = TICK_W + $clog2(NUM_SERVOS + 1);

  localparam logic [TICK_W-1:0] SLOT_TICKS_RESET  = 16'd4500;
  localparam logic [TICK_W-1:0] FRAME_TICKS_RESET = 16'd40000;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS = 2'd1;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // packet characters
  localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;  // '1'
  localparam logic [BYTE_W-1:0] CHAR_LAST  = 8'(48 + NUM_SERVOS);

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [PINS_W-1:0]   servo_pins;
    logic                update_valid;
    logic [UPD_CH_W-1:0] update_channel;
    logic [TICK_W-1:0]   update_width;
  } out_item_t;

  // width store write request from the parser
  typedef struct packed {
    logic              en;
    logic [CH_W-1:0]   addr;
    logic [TICK_W-1:0] data;
  } width_wr_t;

  // frame position
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] tick;
  } pos_t;

  function automatic logic [TICK_W-1:0] reset_width(input logic [CH_W-1:0] idx);
    logic [TICK_W-1:0] w;
    case (32'(idx))
      0:       w = 16'd3000;
      1:       w = 16'd1000;
      2:       w = 16'd4500;
      default: w = 16'd3000;
    endcase
    return w;
  endfunction

  // a slot length of zero acts as one
  function automatic logic [TICK_W-1:0] eff_slot(input logic [TICK_W-1:0] ticks);
    return (ticks == '0) ? TICK_W'(1) : ticks;
  endfunction

endpackage
`default_nettype wire

/* rtl/serial_commanded_servo_pulse_sequencer_core.sv */
// Top level of the six-channel servo pulse sequencer with serial command parser.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries one item per transfer:
//   command 0 is one timer tick, command 1 is one received serial byte.
//   Output channel (out_valid_o/out_ready_i/out_item_o) returns exactly one
//   result per input item, in order: pin levels plus an optional width update.
//   Config port (cfg_we_i/cfg_idx_i/cfg_data_i) writes slot_ticks (index 0)
//   or frame_ticks (index 1); other indexes are dropped. Write only when idle.
// Timing:
//   A transfer passes through stage s1 and the output register to out_valid_o.
//   Throughput is one item per cycle unless the output stalls: the width store
//   is a one-port-read memory read at the transfer edge, the pin decision is
//   made in the following cycle, and the result sits in an output register.
//   Parser and frame position update at the transfer edge; a store write from
//   the same edge is bypassed into the read.
// Reset: asynchronous, active low. Registers return to 4500/40000, the position
//   to slot one tick zero, the parser to idle; stored widths read their power-up
//   values through per-entry valid bits, so no clearing pass is needed.
// Stall: when out_ready_i is low with a result waiting, the pipeline holds and
//   in_ready_o drops once the middle stage is full.
`default_nettype none
module serial_commanded_servo_pulse_sequencer_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire scsp_pkg::in_item_t              in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output scsp_pkg::out_item_t                  out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [scsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [scsp_pkg::TICK_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [scsp_pkg::TICK_W-1:0] slot_ticks_q, frame_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ticks_q  <= scsp_pkg::SLOT_TICKS_RESET;
      frame_ticks_q <= scsp_pkg::FRAME_TICKS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scsp_pkg::REG_SLOT_TICKS:  slot_ticks_q  <= cfg_data_i;
        scsp_pkg::REG_FRAME_TICKS: frame_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: middle stage (s1) and output register
  logic out_valid_q, s1_valid_q;
  logic out_free, s1_move, in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s1_move    = s1_valid_q && out_free;

  // stage 0: parser, frame position, store read
  scsp_pkg::width_wr_t wr;
  scsp_pkg::pos_t      pos;
  logic [scsp_pkg::TICK_W-1:0] rd_data;

  scsp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer && (in_item_i.command == scsp_pkg::CMD_BYTE)),
    .rx_byte_i (in_item_i.rx_byte),
    .wr_o      (wr)
  );

  scsp_frame_timer u_timer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (in_xfer && (in_item_i.command == scsp_pkg::CMD_TICK)),
    .slot_ticks_i  (slot_ticks_q),
    .frame_ticks_i (frame_ticks_q),
    .pos_o         (pos)
  );

  // read address is don't-care in the gap slot
  scsp_width_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (pos.slot[scsp_pkg::CH_W-1:0]),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  // s1 payload
  logic                cmd_q;
  scsp_pkg::pos_t      pos_q;
  scsp_pkg::width_wr_t upd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= in_item_i.command;
      pos_q <= pos;
      upd_q <= wr;
    end
  end

  // stage 1: width latch and pin decision
  logic [scsp_pkg::TICK_W-1:0] latched_q, eff, fresh, w;
  logic                        in_servo;
  logic [15:0]                 onehot;
  scsp_pkg::out_item_t         res;

  assign eff      = scsp_pkg::eff_slot(slot_ticks_q);
  assign fresh    = (rd_data > eff) ? eff : rd_data;
  assign in_servo = pos_q.slot < scsp_pkg::SLOT_W'(scsp_pkg::NUM_SERVOS);
  assign w        = (pos_q.tick == '0) ? fresh : latched_q;
  assign onehot   = 16'd1 << pos_q.slot;

  always_comb begin
    res = '0;
    if (in_servo && (pos_q.tick < w)) begin
      res.servo_pins = onehot[scsp_pkg::PINS_W-1:0];
    end
    if (upd_q.en) begin
      res.update_valid   = 1'b1;
      res.update_channel = scsp_pkg::UPD_CH_W'(upd_q.addr);
      res.update_width   = upd_q.data;
    end
  end

  // only a tick at the start of a servo slot latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= '0;
    end else if (s1_move && (cmd_q == scsp_pkg::CMD_TICK) && in_servo &&
                 (pos_q.tick == '0)) begin
      latched_q <= fresh;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  scsp_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* rtl/scsp_width_mem.sv */
// Pulse width store: small synchronous memory with reset-value valid bits and write bypass.
`default_nettype none
module scsp_width_mem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [scsp_pkg::CH_W-1:0]     rd_addr_i,
  input  wire scsp_pkg::width_wr_t           wr_i,
  output logic      [scsp_pkg::TICK_W-1:0]   rd_data_o
);

  logic [scsp_pkg::TICK_W-1:0]   mem [scsp_pkg::NUM_SERVOS];
  logic [scsp_pkg::NUM_SERVOS-1:0] vld_q;
  logic [scsp_pkg::TICK_W-1:0]   rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read sees a same-cycle write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else if (vld_q[rd_addr_i]) begin
        rd_data_q <= mem[rd_addr_i];
      end else begin
        rd_data_q <= scsp_pkg::reset_width(rd_addr_i);
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* rtl/scsp_parser.sv */
// Serial packet parser: collects <Sn:value> packets and issues width store writes.
`default_nettype none
module scsp_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [scsp_pkg::BYTE_W-1:0]   rx_byte_i,
  output scsp_pkg::width_wr_t                wr_o
);

  logic                             in_packet_q, in_packet_d;
  logic [scsp_pkg::COUNT_W-1:0]     count_q, count_d;
  logic [scsp_pkg::BYTE_W-1:0]      channel_q, channel_d;
  logic [scsp_pkg::TICK_W-1:0]      digits_q, digits_d;
  logic                             ended_q, ended_d;

  logic                             done;
  logic                             is_digit;
  logic [19:0]                      acc;
  logic [scsp_pkg::BYTE_W-1:0]      ch_off;

  assign is_digit = (rx_byte_i >= scsp_pkg::CHAR_ZERO) && (rx_byte_i <= scsp_pkg::CHAR_NINE);
  assign acc      = 20'(digits_q) * 20'd10 + 20'(rx_byte_i - scsp_pkg::CHAR_ZERO);

  always_comb begin
    in_packet_d = in_packet_q;
    count_d     = count_q;
    channel_d   = channel_q;
    digits_d    = digits_q;
    ended_d     = ended_q;
    done        = 1'b0;
    if (!in_packet_q) begin
      if (rx_byte_i == scsp_pkg::CHAR_OPEN) begin
        in_packet_d = 1'b1;
        count_d     = '0;
        channel_d   = '0;
        digits_d    = '0;
        ended_d     = 1'b0;
      end
    end else if (rx_byte_i == scsp_pkg::CHAR_CLOSE) begin
      done = 1'b1;
    end else begin
      if (count_q == scsp_pkg::COUNT_W'(1)) begin
        channel_d = rx_byte_i;
      end
      if ((count_q >= scsp_pkg::COUNT_W'(3)) && !ended_q) begin
        if (is_digit) begin
          digits_d = (acc > 20'd65535) ? '1 : acc[scsp_pkg::TICK_W-1:0];
        end else begin
          ended_d = 1'b1;
        end
      end
      count_d = count_q + scsp_pkg::COUNT_W'(1);
      done    = (count_d >= scsp_pkg::COUNT_W'(scsp_pkg::MAX_PACKET_CHARS));
    end
  end

  assign ch_off  = channel_d - scsp_pkg::CHAR_ONE;
  assign wr_o.en = step_i && in_packet_q && done && (count_d >= scsp_pkg::COUNT_W'(4)) &&
                   (channel_d >= scsp_pkg::CHAR_ONE) && (channel_d <= scsp_pkg::CHAR_LAST);
  assign wr_o.addr = ch_off[scsp_pkg::CH_W-1:0];
  assign wr_o.data = digits_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      count_q     <= '0;
      channel_q   <= '0;
      digits_q    <= '0;
      ended_q     <= 1'b0;
    end else if (step_i) begin
      if (done) begin
        in_packet_q <= 1'b0;
        count_q     <= '0;
        channel_q   <= '0;
        digits_q    <= '0;
        ended_q     <= 1'b0;
      end else begin
        in_packet_q <= in_packet_d;
        count_q     <= count_d;
        channel_q   <= channel_d;
        digits_q    <= digits_d;
        ended_q     <= ended_d;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/scsp_frame_timer.sv */
// Frame position counter: slot index and tick within slot, gap handling.
`default_nettype none
module scsp_frame_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [scsp_pkg::TICK_W-1:0]   slot_ticks_i,
  input  wire logic [scsp_pkg::TICK_W-1:0]   frame_ticks_i,
  output scsp_pkg::pos_t                     pos_o
);

  logic [scsp_pkg::SLOT_W-1:0]  slot_q, slot_d, slot_inc;
  logic [scsp_pkg::TICK_W-1:0]  tick_q, tick_d;
  logic [scsp_pkg::TICK_W-1:0]  eff, gap, len;
  logic [scsp_pkg::USED_W-1:0]  used;

  assign eff  = scsp_pkg::eff_slot(slot_ticks_i);
  assign used = scsp_pkg::USED_W'(eff) * scsp_pkg::USED_W'(scsp_pkg::NUM_SERVOS);
  assign gap  = (scsp_pkg::USED_W'(frame_ticks_i) > used) ?
                scsp_pkg::TICK_W'(scsp_pkg::USED_W'(frame_ticks_i) - used) : '0;
  assign len  = (slot_q < scsp_pkg::SLOT_W'(scsp_pkg::NUM_SERVOS)) ? eff : gap;
  assign slot_inc = slot_q + scsp_pkg::SLOT_W'(1);

  always_comb begin
    slot_d = slot_q;
    tick_d = tick_q + scsp_pkg::TICK_W'(1);
    if ({1'b0, tick_q} + 17'd1 >= {1'b0, len}) begin
      tick_d = '0;
      slot_d = slot_inc;
      if ((slot_inc == scsp_pkg::SLOT_W'(scsp_pkg::NUM_SERVOS)) && (gap == '0)) begin
        slot_d = '0;
      end else if (slot_inc > scsp_pkg::SLOT_W'(scsp_pkg::NUM_SERVOS)) begin
        slot_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      tick_q <= '0;
    end else if (tick_i) begin
      slot_q <= slot_d;
      tick_q <= tick_d;
    end
  end

  assign pos_o.slot = slot_q;
  assign pos_o.tick = tick_q;

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the servo pulse sequencer core: directed rows, then random traffic.
`timescale 1ns / 100ps
module testbench;
  import scsp_pkg::*;

  // limit on cycles without a transfer on either channel before the block counts as hung
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned NUM_PHASES = 12;
  // indexes past the two real registers, written with junk to prove they are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_item_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [TICK_W-1:0]    cfg_data_i;

  serial_commanded_servo_pulse_sequencer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the sequencer: timing registers, stored widths, frame position
  // and packet parser, all at the block's widths.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] cfg_slot;
  logic [TICK_W-1:0] cfg_frame;
  logic [TICK_W-1:0] width_mem [NUM_SERVOS];
  logic [2:0]        frame_slot;     // NUM_SERVOS means the idle gap
  logic [TICK_W-1:0] frame_tick;
  logic [TICK_W-1:0] held_width;
  logic              pkt_open;
  logic [3:0]        pkt_len;
  logic [BYTE_W-1:0] pkt_chan;
  logic [TICK_W-1:0] pkt_value;
  logic              pkt_digits_done;

  out_item_t pins_due [$];           // pin/update results owed by the block, oldest first
  int unsigned errors;
  bit          calm;                 // no idling on either side
  int unsigned gap_odds;             // 1-in-N chance of a sender gap, 0 = never

  // slot length of zero behaves as one
  function automatic int unsigned slot_span();
    return (cfg_slot == '0) ? 1 : int'(cfg_slot);
  endfunction

  // gap after the servo slots; vanishes when the slots fill the frame
  function automatic int unsigned gap_span();
    int unsigned used;
    used = NUM_SERVOS * slot_span();
    return (int'(cfg_frame) > used) ? int'(cfg_frame) - used : 0;
  endfunction

  // pin level at the current position; on a slot's first tick the width is
  // taken fresh from the store (clipped to the slot) and optionally held
  function automatic logic [PINS_W-1:0] pin_state(input bit hold_it);
    logic [TICK_W-1:0] w;
    if (frame_slot >= NUM_SERVOS) return '0;
    if (frame_tick == '0) begin
      w = (int'(width_mem[frame_slot]) > slot_span()) ? TICK_W'(slot_span())
                                                       : width_mem[frame_slot];
      if (hold_it) held_width = w;
    end else begin
      w = held_width;
    end
    return (frame_tick < w) ? PINS_W'(1 << frame_slot) : '0;
  endfunction

  function automatic void step_frame();
    int unsigned span;
    span = (frame_slot < NUM_SERVOS) ? slot_span() : gap_span();
    // register changes mid-slot: the slot ends once the next tick reaches or passes it
    if (32'(frame_tick) + 1 >= span) begin
      frame_tick = '0;
      frame_slot = frame_slot + 3'd1;
      if (frame_slot == NUM_SERVOS && gap_span() == 0) frame_slot = '0;
      else if (frame_slot > NUM_SERVOS) frame_slot = '0;
    end else begin
      frame_tick = frame_tick + 1'b1;
    end
  endfunction

  function automatic void drop_packet();
    pkt_open        = 1'b0;
    pkt_len         = '0;
    pkt_chan        = '0;
    pkt_value       = '0;
    pkt_digits_done = 1'b0;
  endfunction

  function automatic out_item_t servo_step(input in_item_t it);
    out_item_t   r;
    bit          done;
    int unsigned acc;
    logic [2:0]  ch;
    r = '0;
    if (it.command == CMD_TICK) begin
      r.servo_pins = pin_state(1'b1);
      step_frame();
    end else begin
      if (!pkt_open) begin
        // idle parser only wakes on the opening bracket
        if (it.rx_byte == CHAR_OPEN) begin
          drop_packet();
          pkt_open = 1'b1;
        end
      end else begin
        done = 1'b0;
        if (it.rx_byte == CHAR_CLOSE) begin
          done = 1'b1;
        end else begin
          if (pkt_len == 4'd1) pkt_chan = it.rx_byte;
          if (pkt_len >= 4'd3 && !pkt_digits_done) begin
            if (it.rx_byte >= CHAR_ZERO && it.rx_byte <= CHAR_NINE) begin
              acc = 32'(pkt_value) * 10 + 32'(it.rx_byte - CHAR_ZERO);
              pkt_value = (acc > 32'hFFFF) ? 16'hFFFF : acc[TICK_W-1:0];
            end else begin
              pkt_digits_done = 1'b1;
            end
          end
          pkt_len = pkt_len + 4'd1;
          if (pkt_len >= MAX_PACKET_CHARS) done = 1'b1;
        end
        if (done) begin
          // short packets and bad channel characters write nothing
          if (pkt_len >= 4'd4 && pkt_chan >= CHAR_ONE && pkt_chan <= CHAR_LAST) begin
            ch = 3'(pkt_chan - CHAR_ONE);
            width_mem[ch]    = pkt_value;
            r.update_valid   = 1'b1;
            r.update_channel = ch;
            r.update_width   = pkt_value;
          end
          drop_packet();
        end
      end
      // byte items see the level after any width update they caused
      r.servo_pins = pin_state(1'b0);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  out_item_t owed;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pins_due.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 64'(out_item_o), 64'd0);
      end else begin
        owed = pins_due.pop_front();
        if (out_item_o.servo_pins !== owed.servo_pins)
          flag_mismatch("servo_pins", 64'(out_item_o.servo_pins), 64'(owed.servo_pins));
        if (out_item_o.update_valid !== owed.update_valid)
          flag_mismatch("update_valid", 64'(out_item_o.update_valid),
                        64'(owed.update_valid));
        if (out_item_o.update_channel !== owed.update_channel)
          flag_mismatch("update_channel", 64'(out_item_o.update_channel),
                        64'(owed.update_channel));
        if (out_item_o.update_width !== owed.update_width)
          flag_mismatch("update_width", 64'(out_item_o.update_width),
                        64'(owed.update_width));
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("serial_commanded_servo_pulse_sequencer_core verification failed");
        $finish;
      end
    end
  end

  // receiver: random ready runs, each followed by a random stall two times in three, none once calm
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // one input transfer; the owed result is either typed in or predicted
  task automatic offer(input in_item_t it, input bit fixed, input out_item_t typed);
    out_item_t predicted;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = servo_step(it);
    pins_due.push_back(fixed ? typed : predicted);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.command = CMD_BYTE;
    it.rx_byte = b;
    offer(it, 1'b0, '0);
  endtask

  task automatic send_ticks(input int unsigned n);
    in_item_t it;
    repeat (n) begin
      it.command = CMD_TICK;
      it.rx_byte = 8'($urandom_range(0, 255));   // ignored on ticks
      offer(it, 1'b0, '0);
    end
  endtask

  function automatic logic [BYTE_W-1:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] any_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // mostly well-formed <Sn:value> with random content; now and then a bad
  // lead, channel or separator, a run of raw digits, or junk after the value
  task automatic send_packet(output int unsigned n);
    logic [BYTE_W-1:0] pkt [$];
    string             digits;
    int unsigned       v;
    pkt.push_back(CHAR_OPEN);
    pkt.push_back(($urandom_range(0, 7) == 0) ? any_byte() : 8'h53);   // 'S'
    pkt.push_back(($urandom_range(0, 9) == 0) ? any_byte()
                  : CHAR_ONE + 8'($urandom_range(0, NUM_SERVOS - 1)));
    pkt.push_back(($urandom_range(0, 7) == 0) ? any_byte() : 8'h3A);   // ':'
    if ($urandom_range(0, 5) == 0) begin
      // may be empty, may run past the length limit, leading zeros allowed
      repeat ($urandom_range(0, 7)) pkt.push_back(any_digit());
    end else begin
      // keep widths mostly around the slot length so pins really toggle
      v = $urandom_range(0, 2 * slot_span() + 2);
      digits = $sformatf("%0d", v);
      for (int k = 0; k < digits.len(); k++) pkt.push_back(digits[k]);
    end
    if ($urandom_range(0, 7) == 0) begin
      pkt.push_back(any_byte());
      pkt.push_back(any_digit());
    end
    pkt.push_back(CHAR_CLOSE);
    n = pkt.size();
    foreach (pkt[i]) send_byte(pkt[i]);
  endtask

  // opening bracket followed by a random tail, biased to the packet characters
  task automatic send_broken(output int unsigned n);
    n = $urandom_range(0, 12);
    send_byte(CHAR_OPEN);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       send_byte(CHAR_OPEN);
        1:       send_byte(CHAR_CLOSE);
        2:       send_byte(any_digit());
        default: send_byte(any_byte());
      endcase
    end
    n = n + 1;
  endtask

  // stop sending, let every owed result drain, then cover the pipeline latency
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // junk to a spare index, then both timing registers; write enable stays high
  task automatic load_timing(input logic [TICK_W-1:0] slot, input logic [TICK_W-1:0] frame);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= $urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI;
    cfg_data_i <= TICK_W'($urandom_range(0, 65535));
    @(posedge clk_i);
    cfg_idx_i  <= REG_SLOT_TICKS;
    cfg_data_i <= slot;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FRAME_TICKS;
    cfg_data_i <= frame;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_slot  = slot;
    cfg_frame = frame;
  endtask

  // directed rows: typed result only where it is obvious, else predicted
  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } script_row_t;
  script_row_t script [$];

  task automatic add_row(input logic cmd, input logic [BYTE_W-1:0] b, input bit fixed,
                         input logic [PINS_W-1:0] pins, input logic uv,
                         input logic [UPD_CH_W-1:0] ch, input logic [TICK_W-1:0] w);
    script_row_t row;
    row.item.command        = cmd;
    row.item.rx_byte        = b;
    row.fixed               = fixed;
    row.want.servo_pins     = pins;
    row.want.update_valid   = uv;
    row.want.update_channel = ch;
    row.want.update_width   = w;
    script.push_back(row);
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) add_row(CMD_BYTE, s[k], 1'b0, '0, 1'b0, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned n;
    logic [TICK_W-1:0] slot;
    logic [TICK_W-1:0] frame;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_SLOT_TICKS;
    cfg_data_i <= '0;
    errors     = 0;
    calm       = 1'b0;
    gap_odds   = 3;

    // shadow state at reset
    cfg_slot  = SLOT_TICKS_RESET;
    cfg_frame = FRAME_TICKS_RESET;
    foreach (width_mem[k]) width_mem[k] = 16'd3000;
    width_mem[1] = 16'd1000;
    width_mem[2] = 16'd4500;
    frame_slot = '0;
    frame_tick = '0;
    held_width = '0;
    drop_packet();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset timing: servo 1 starts its slot with width 3000,
    // so every row below sees only pin 1 high.
    add_row(CMD_TICK, 8'h00, 1'b1, 6'h01, 1'b0, 3'd0, 16'd0);  // first tick after reset
    add_row(CMD_BYTE, 8'h00, 1'b1, 6'h01, 1'b0, 3'd0, 16'd0);  // stray byte, parser idle
    add_text("<S2:0");
    add_row(CMD_BYTE, CHAR_CLOSE, 1'b1, 6'h01, 1'b1, 3'd1, 16'd0);  // zero width to servo 2
    add_text("<S7:1");
    add_row(CMD_BYTE, CHAR_CLOSE, 1'b1, 6'h01, 1'b0, 3'd0, 16'd0);  // channel out of range
    add_text("<S1");
    add_row(CMD_BYTE, CHAR_CLOSE, 1'b1, 6'h01, 1'b0, 3'd0, 16'd0);  // too short to write
    add_text("<S6:99999");
    // ninth character closes the packet; 99999 clamps to the 16-bit ceiling
    add_row(CMD_BYTE, 8'hFF, 1'b1, 6'h01, 1'b1, 3'd5, 16'hFFFF);
    add_row(CMD_TICK, 8'hFF, 1'b0, '0, 1'b0, '0, '0);
    add_row(CMD_TICK, 8'h00, 1'b0, '0, 1'b0, '0, '0);
    foreach (script[i]) offer(script[i].item, script[i].fixed, script[i].want);

    // Random phases: timing extremes first, then short frames where every
    // slot and any gap come around many times. The last phase runs calm.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin slot = 16'd1;     frame = 16'd1;     end
        1:       begin slot = 16'd0;     frame = 16'd9;     end
        2:       begin slot = 16'hFFFF;  frame = 16'hFFFF;  end
        3:       begin slot = 16'hFFFF;  frame = 16'd1;     end
        4:       begin slot = 16'd3;     frame = 16'hFFFF;  end
        default: begin
          slot  = TICK_W'($urandom_range(2, 10));
          frame = TICK_W'($urandom_range(0, 90));
        end
      endcase
      settle();
      load_timing(slot, frame);
      calm = (p == NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 10;
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            n = $urandom_range(1, 40);
            send_ticks(n);
            sent += n;
          end
          5, 6, 7: begin
            send_packet(n);
            sent += n;
          end
          8: begin
            send_broken(n);
            sent += n;
          end
          default: begin
            // noise while the parser is most likely idle; not counted
            repeat ($urandom_range(1, 4)) send_byte(any_byte());
          end
        endcase
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (pins_due.size() != 0)
      flag_mismatch("results never delivered", 64'(pins_due.size()), 64'd0);
    if (errors == 0) begin
      $display("serial_commanded_servo_pulse_sequencer_core verification clean");
    end else begin
      $display("serial_commanded_servo_pulse_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
